// ===== rtl/sct_pkg.sv =====
// types, constants and helpers shared by the s-expression tokenizer modules
// no dependencies
`timescale 1ns / 1ps

package sct_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic [7:0] next_char;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  token_char;
        logic        token_start;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        last_in_run;
    } t_out_item;

    localparam int RESULT_LIMIT = 11;
    localparam int CNT_BITS     = 4;
    localparam int DEPTH_BITS   = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = 2;
    localparam int QCNT_BITS    = 3;

    localparam logic [2:0] TOK_CHAR  = 3'd0;
    localparam logic [2:0] TOK_END   = 3'd1;
    localparam logic [2:0] TOK_OPEN  = 3'd2;
    localparam logic [2:0] TOK_CLOSE = 3'd3;
    localparam logic [2:0] TOK_QUOTE = 3'd4;
    localparam logic [2:0] TOK_ERROR = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_TICK  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;

    localparam int SEG_COUNT = 7;
    localparam int SEG_BITS  = 3;
    localparam logic [SEG_BITS-1:0] SEG_PRE_END  = 3'd0;
    localparam logic [SEG_BITS-1:0] SEG_PRE_CL   = 3'd1;
    localparam logic [SEG_BITS-1:0] SEG_ACT      = 3'd2;
    localparam logic [SEG_BITS-1:0] SEG_QUOTE    = 3'd3;
    localparam logic [SEG_BITS-1:0] SEG_POPS     = 3'd4;
    localparam logic [SEG_BITS-1:0] SEG_POST_END = 3'd5;
    localparam logic [SEG_BITS-1:0] SEG_POST_CL  = 3'd6;

    // one classified source byte: counts of each token group it causes
    typedef struct packed {
        logic                pre_end;
        logic [CNT_BITS-1:0] pre_cnt;
        logic                act_valid;
        logic [2:0]          act_kind;
        logic                act_quote;
        logic [CNT_BITS-1:0] act_cnt;
        logic [7:0]          ch;
        logic                start;
        logic                post_end;
        logic [CNT_BITS-1:0] post_cnt;
        logic [15:0]         line;
        logic [15:0]         col;
    } t_cmd;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
    endfunction

endpackage

// ===== rtl/sct_front.sv =====
// front end: accepts source bytes, tracks lexer state and the quote stack,
// and turns each byte that causes tokens into a token command; uses sct_pkg
`timescale 1ns / 1ps

module sct_front #(
    parameter int QUOTE_STACK_DEPTH = 8,
    parameter int MAX_WORD_QUOTES   = 7,
    parameter int POSITION_BITS     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sct_pkg::t_in_item i_item,
    output logic              o_push,
    output sct_pkg::t_cmd     o_cmd,
    input  logic              i_full
);

    localparam int LW = $clog2(QUOTE_STACK_DEPTH + 1);
    localparam int PW = $clog2(MAX_WORD_QUOTES + 1);
    localparam int CW = $clog2(QUOTE_STACK_DEPTH + MAX_WORD_QUOTES + (1 << sct_pkg::CNT_BITS));
    localparam int PB = POSITION_BITS;
    localparam int DB = sct_pkg::DEPTH_BITS;

    logic          r_in_string, n_in_string;
    logic          r_in_comment, n_in_comment;
    logic          r_name_open, n_name_open;
    logic [PW-1:0] r_pwc, n_pwc;
    logic [DB-1:0] r_depth, n_depth;
    logic [PB-1:0] r_line, n_line;
    logic [PB-1:0] r_col, n_col;
    logic [LW-1:0] r_nruns, n_nruns;
    logic [LW-1:0] r_qcnt, n_qcnt;

    // quote stack as run-length shift register, top at index 0
    logic [DB-1:0] r_run_val [QUOTE_STACK_DEPTH];
    logic [LW-1:0] r_run_len [QUOTE_STACK_DEPTH];

    logic          accept;
    logic [7:0]    c;
    logic [7:0]    nx;
    logic [PB-1:0] col_now;
    logic          st_push;
    logic          st_pop;
    logic          st_merge;
    logic [LW-1:0] push_n;
    logic [CW-1:0] push_k;
    logic [CW-1:0] push_avail;
    sct_pkg::t_cmd cmd;

    function automatic logic [sct_pkg::CNT_BITS-1:0] clamp_cnt(input logic [CW-1:0] v);
        return (v > CW'(sct_pkg::RESULT_LIMIT)) ? sct_pkg::CNT_BITS'(sct_pkg::RESULT_LIMIT)
                                                : sct_pkg::CNT_BITS'(v);
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign c       = i_item.char_in;
    assign nx      = i_item.next_char;
    assign col_now = (r_col != {PB{1'b1}}) ? r_col + 1'b1 : r_col;
    assign st_merge = (r_nruns != '0) && (r_run_val[0] == r_depth);

    always_comb begin
        n_in_string  = r_in_string;
        n_in_comment = r_in_comment;
        n_name_open  = r_name_open;
        n_pwc        = r_pwc;
        n_depth      = r_depth;
        n_line       = r_line;
        n_col        = col_now;
        st_push      = 1'b0;
        st_pop       = 1'b0;
        push_k       = '0;
        push_avail   = '0;
        push_n       = '0;
        cmd          = '0;
        cmd.line     = 16'(r_line);
        cmd.col      = 16'(col_now);

        if (r_in_comment) begin
            if (c == sct_pkg::CH_NL) begin
                n_in_comment = 1'b0;
            end
        end else if (!r_in_string && (sct_pkg::is_space(c) || c == sct_pkg::CH_SEMI ||
                     c == sct_pkg::CH_LP || c == sct_pkg::CH_RP || c == sct_pkg::CH_TICK)) begin
            // break byte ends the open name
            if (r_name_open) begin
                cmd.pre_end = 1'b1;
                cmd.pre_cnt = clamp_cnt(CW'(r_pwc));
                n_pwc       = '0;
                n_name_open = 1'b0;
            end
            if (c == sct_pkg::CH_SEMI) begin
                n_in_comment = 1'b1;
            end else if (c == sct_pkg::CH_LP) begin
                cmd.act_valid = 1'b1;
                cmd.act_kind  = sct_pkg::TOK_OPEN;
                if (r_depth != {DB{1'b1}}) begin
                    n_depth = r_depth + 1'b1;
                end
            end else if (c == sct_pkg::CH_RP) begin
                cmd.act_valid = 1'b1;
                cmd.act_kind  = sct_pkg::TOK_CLOSE;
                if (r_depth != '0) begin
                    n_depth = r_depth - 1'b1;
                end
                if (r_nruns != '0 && r_run_val[0] == n_depth) begin
                    st_pop      = 1'b1;
                    cmd.act_cnt = clamp_cnt(CW'(r_run_len[0]));
                end
            end else if (c == sct_pkg::CH_TICK) begin
                cmd.act_valid = 1'b1;
                if (sct_pkg::is_space(nx)) begin
                    cmd.act_kind = sct_pkg::TOK_ERROR;
                end else begin
                    cmd.act_kind  = sct_pkg::TOK_OPEN;
                    cmd.act_quote = 1'b1;
                    if (nx == sct_pkg::CH_LP) begin
                        push_k     = CW'(n_pwc) + 1'b1;
                        push_avail = CW'(QUOTE_STACK_DEPTH) - CW'(r_qcnt);
                        push_n     = LW'((push_k < push_avail) ? push_k : push_avail);
                        st_push    = (push_n != '0);
                        n_pwc      = '0;
                    end else if (n_pwc < PW'(MAX_WORD_QUOTES)) begin
                        n_pwc = n_pwc + 1'b1;
                    end
                end
            end
        end else begin
            if (c == sct_pkg::CH_DQUOTE) begin
                n_in_string = !r_in_string;
            end
            cmd.act_valid = 1'b1;
            cmd.act_kind  = sct_pkg::TOK_CHAR;
            cmd.ch        = c;
            cmd.start     = !r_name_open;
            n_name_open   = 1'b1;
        end

        if (c == sct_pkg::CH_NL) begin
            if (r_line != {PB{1'b1}}) begin
                n_line = r_line + 1'b1;
            end
            n_col = '0;
        end

        if (i_item.end_of_input) begin
            cmd.post_end = n_name_open;
            cmd.post_cnt = clamp_cnt(CW'(n_pwc));
            n_name_open  = 1'b0;
            n_pwc        = '0;
        end

        n_nruns = r_nruns;
        n_qcnt  = r_qcnt;
        if (st_pop) begin
            n_nruns = r_nruns - 1'b1;
            n_qcnt  = r_qcnt - r_run_len[0];
        end else if (st_push) begin
            n_qcnt = r_qcnt + push_n;
            if (!st_merge) begin
                n_nruns = r_nruns + 1'b1;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.pre_end || cmd.act_valid || cmd.post_end ||
                               cmd.post_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string  <= 1'b0;
            r_in_comment <= 1'b0;
            r_name_open  <= 1'b0;
            r_pwc        <= '0;
            r_depth      <= '0;
            r_line       <= PB'(1);
            r_col        <= '0;
            r_nruns      <= '0;
            r_qcnt       <= '0;
        end else if (accept) begin
            r_in_string  <= n_in_string;
            r_in_comment <= n_in_comment;
            r_name_open  <= n_name_open;
            r_pwc        <= n_pwc;
            r_depth      <= n_depth;
            r_line       <= n_line;
            r_col        <= n_col;
            r_nruns      <= n_nruns;
            r_qcnt       <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (st_pop) begin
                for (int i = 0; i < QUOTE_STACK_DEPTH - 1; i++) begin
                    r_run_val[i] <= r_run_val[i+1];
                    r_run_len[i] <= r_run_len[i+1];
                end
            end else if (st_push) begin
                if (st_merge) begin
                    r_run_len[0] <= r_run_len[0] + push_n;
                end else begin
                    for (int i = 1; i < QUOTE_STACK_DEPTH; i++) begin
                        r_run_val[i] <= r_run_val[i-1];
                        r_run_len[i] <= r_run_len[i-1];
                    end
                    r_run_val[0] <= r_depth;
                    r_run_len[0] <= push_n;
                end
            end
        end
    end

    a_runs_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nruns <= r_qcnt)
        else $error("quote stack has more runs than entries");

    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nruns == '0) == (r_qcnt == '0))
        else $error("quote stack run count and entry count disagree on empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= LW'(QUOTE_STACK_DEPTH))
        else $error("quote stack count beyond depth");

endmodule

// ===== rtl/sct_queue.sv =====
// short command queue between front and back end
// uses sct_pkg for the command type and depth
`timescale 1ns / 1ps

module sct_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sct_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sct_pkg::t_cmd o_data
);

    sct_pkg::t_cmd                   r_mem [sct_pkg::QUEUE_DEPTH];
    logic [sct_pkg::QPTR_BITS-1:0]   r_wptr;
    logic [sct_pkg::QPTR_BITS-1:0]   r_rptr;
    logic [sct_pkg::QCNT_BITS-1:0]   r_count;
    logic                            do_pop;

    assign o_full  = (r_count == sct_pkg::QCNT_BITS'(sct_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request pushed into full command queue");

endmodule

// ===== rtl/sct_back.sv =====
// back end: expands one command per run into token requests, one per cycle
// while the output is not stalled, keeps the first eleven and marks the last; uses sct_pkg
`timescale 1ns / 1ps

module sct_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  sct_pkg::t_cmd      i_q_data,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output sct_pkg::t_out_item o_item
);

    localparam int CB = sct_pkg::CNT_BITS;
    localparam int SB = sct_pkg::SEG_BITS;

    logic                 r_busy;
    logic [SB-1:0]        r_seg;
    logic [CB-1:0]        r_rem;
    logic [CB-1:0]        r_num;
    logic [CB-1:0]        r_cnt [sct_pkg::SEG_COUNT];
    logic [2:0]           r_akind;
    logic [7:0]           r_ch;
    logic                 r_start;
    logic [15:0]          r_line;
    logic [15:0]          r_col;
    logic                 r_ovalid;
    sct_pkg::t_out_item   r_oitem;

    logic [CB-1:0]        l_cnt [sct_pkg::SEG_COUNT];
    logic [SB-1:0]        l_first;
    logic [SB-1:0]        nxt_seg;
    logic                 more_later;
    logic                 adv;
    logic                 last;
    logic                 load;
    sct_pkg::t_out_item   res;

    always_comb begin
        l_cnt[sct_pkg::SEG_PRE_END]  = CB'(i_q_data.pre_end);
        l_cnt[sct_pkg::SEG_PRE_CL]   = i_q_data.pre_cnt;
        l_cnt[sct_pkg::SEG_ACT]      = CB'(i_q_data.act_valid);
        l_cnt[sct_pkg::SEG_QUOTE]    = CB'(i_q_data.act_quote);
        l_cnt[sct_pkg::SEG_POPS]     = i_q_data.act_cnt;
        l_cnt[sct_pkg::SEG_POST_END] = CB'(i_q_data.post_end);
        l_cnt[sct_pkg::SEG_POST_CL]  = i_q_data.post_cnt;
        l_first = '0;
        for (int j = sct_pkg::SEG_COUNT - 1; j >= 0; j--) begin
            if (l_cnt[j] != '0) begin
                l_first = SB'(j);
            end
        end
    end

    always_comb begin
        nxt_seg    = r_seg;
        more_later = 1'b0;
        for (int j = sct_pkg::SEG_COUNT - 1; j >= 0; j--) begin
            if (j > int'(r_seg) && r_cnt[j] != '0) begin
                nxt_seg    = SB'(j);
                more_later = 1'b1;
            end
        end
    end

    assign adv  = r_busy && (!r_ovalid || i_ready);
    assign last = ((r_rem == CB'(1)) && !more_later) ||
                  (r_num == CB'(sct_pkg::RESULT_LIMIT - 1));
    assign load = i_q_valid && (!r_busy || (adv && last));
    assign o_q_pop = load;

    always_comb begin
        res               = '0;
        res.line_number   = r_line;
        res.column_number = r_col;
        res.last_in_run   = last;
        case (r_seg)
            sct_pkg::SEG_PRE_END:  res.token_kind = sct_pkg::TOK_END;
            sct_pkg::SEG_PRE_CL:   res.token_kind = sct_pkg::TOK_CLOSE;
            sct_pkg::SEG_ACT: begin
                res.token_kind = r_akind;
                if (r_akind == sct_pkg::TOK_CHAR) begin
                    res.token_char  = r_ch;
                    res.token_start = r_start;
                end
            end
            sct_pkg::SEG_QUOTE:    res.token_kind = sct_pkg::TOK_QUOTE;
            sct_pkg::SEG_POPS:     res.token_kind = sct_pkg::TOK_CLOSE;
            sct_pkg::SEG_POST_END: res.token_kind = sct_pkg::TOK_END;
            sct_pkg::SEG_POST_CL:  res.token_kind = sct_pkg::TOK_CLOSE;
            default:               res.token_kind = sct_pkg::TOK_ERROR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_seg    <= '0;
            r_rem    <= '0;
            r_num    <= '0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_seg  <= l_first;
                r_rem  <= l_cnt[l_first];
                r_num  <= '0;
            end else if (adv) begin
                r_num <= r_num + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end else if (r_rem != CB'(1)) begin
                    r_rem <= r_rem - 1'b1;
                end else begin
                    r_seg <= nxt_seg;
                    r_rem <= r_cnt[nxt_seg];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_oitem <= res;
        end
        if (load) begin
            r_cnt   <= l_cnt;
            r_akind <= i_q_data.act_kind;
            r_ch    <= i_q_data.ch;
            r_start <= i_q_data.start;
            r_line  <= i_q_data.line;
            r_col   <= i_q_data.col;
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

    a_num_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_num < CB'(sct_pkg::RESULT_LIMIT))
        else $error("run emitted more than the result limit");

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem != '0)
        else $error("active segment has no requests left");

endmodule

// ===== rtl/sexpr_char_tokenizer.sv =====
// top level of the s-expression character tokenizer
// instantiates sct_front, sct_queue and sct_back; uses sct_pkg
`timescale 1ns / 1ps

// One source byte is taken per cycle while the four-entry command queue has
// room. The front end classifies each byte and updates string, comment, name,
// depth, line/column and quote stack state in the same cycle. The back end
// hands out one token request per cycle from an output register while the
// receiver is ready; a byte with n tokens (n up to 11) holds it until all n
// are out, and bytes with no tokens (comments, whitespace outside names) cost
// nothing there. Sustained input rate is one byte per cycle if bytes average
// at most one token and the receiver keeps up; longer bursts fill the queue
// and then hold off input. Tokens pass queue, command and output registers.
module sexpr_char_tokenizer #(
    parameter int QUOTE_STACK_DEPTH = 8,
    parameter int MAX_WORD_QUOTES   = 7,
    parameter int POSITION_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sct_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sct_pkg::t_out_item o_out_item
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    sct_pkg::t_cmd f_cmd;
    sct_pkg::t_cmd q_cmd;

    sct_front #(
        .QUOTE_STACK_DEPTH (QUOTE_STACK_DEPTH),
        .MAX_WORD_QUOTES   (MAX_WORD_QUOTES),
        .POSITION_BITS     (POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_push  (q_push),
        .o_cmd   (f_cmd),
        .i_full  (q_full)
    );

    sct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    sct_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for sexpr_char_tokenizer: a built-in lexer predictor feeds
// a token scoreboard, stimulus is directed text, random s-expression programs and
// random byte items; depends on rtl/sct_pkg.sv and rtl/sexpr_char_tokenizer.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STACK_DEPTH    = 8;
    localparam int WORD_QUOTE_MAX = 7;
    localparam int POS_LIMIT      = 65535;
    localparam int DEPTH_LIMIT    = 65535;
    localparam int RANDOM_ITEMS   = 380;
    localparam int MAX_ERR_PRINTS = 20;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_out_ready = 1'b0;
    sct_pkg::t_in_item  i_in_item   = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    sct_pkg::t_out_item o_out_item;

    sexpr_char_tokenizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lexer predictor state
    logic lx_in_string  = 1'b0;
    logic lx_in_comment = 1'b0;
    logic lx_name_open  = 1'b0;
    int   lx_word_closes = 0;
    int   lx_depth       = 0;
    int   lx_stack_cnt   = 0;
    int   lx_line        = 1;
    int   lx_col         = 0;
    int   lx_stack [STACK_DEPTH];
    int   tok_line;
    int   tok_col;
    bit   burst_cut;

    sct_pkg::t_out_item burst_toks[$];
    sct_pkg::t_out_item tok_expect[$];
    sct_pkg::t_in_item  req_q[$];
    logic [7:0] src_text[$];

    int  bad_cnt     = 0;
    int  items_taken = 0;
    int  toks_seen   = 0;
    int  max_burst   = 0;
    int  cut_cnt     = 0;
    int  max_stack   = 0;
    int  max_pending = 0;
    bit  in_fire     = 1'b0;

    function automatic logic is_blank(logic [7:0] c);
        return c == sct_pkg::CH_SPACE || c == sct_pkg::CH_NL || c == sct_pkg::CH_TAB;
    endfunction

    function automatic void put_tok(logic [2:0] kind, logic [7:0] ch, logic start);
        sct_pkg::t_out_item t;
        if (burst_toks.size() >= sct_pkg::RESULT_LIMIT) begin
            burst_cut = 1'b1;
            return;
        end
        t.token_kind    = kind;
        t.token_char    = ch;
        t.token_start   = start;
        t.line_number   = 16'(tok_line);
        t.column_number = 16'(tok_col);
        t.last_in_run   = 1'b0;
        burst_toks.push_back(t);
    endfunction

    function automatic void flush_word_closes();
        while (lx_word_closes > 0) begin
            put_tok(sct_pkg::TOK_CLOSE, 8'h00, 1'b0);
            lx_word_closes--;
        end
    endfunction

    function automatic void finish_name();
        if (lx_name_open) begin
            put_tok(sct_pkg::TOK_END, 8'h00, 1'b0);
            lx_name_open = 1'b0;
            flush_word_closes();
        end
    endfunction

    // one source byte: update lexer state and queue the tokens it causes
    function automatic void lex_byte(sct_pkg::t_in_item it);
        logic [7:0]         c;
        sct_pkg::t_out_item t;
        c = it.char_in;
        burst_toks.delete();
        burst_cut = 1'b0;
        if (lx_col < POS_LIMIT) lx_col++;
        tok_line = lx_line;
        tok_col  = lx_col;
        if (lx_in_comment) begin
            if (c == sct_pkg::CH_NL) lx_in_comment = 1'b0;
        end else if (!lx_in_string && c == sct_pkg::CH_SEMI) begin
            finish_name();
            lx_in_comment = 1'b1;
        end else if (!lx_in_string && (is_blank(c) || c == sct_pkg::CH_LP ||
                                       c == sct_pkg::CH_RP || c == sct_pkg::CH_TICK)) begin
            finish_name();
            if (c == sct_pkg::CH_LP) begin
                put_tok(sct_pkg::TOK_OPEN, 8'h00, 1'b0);
                if (lx_depth < DEPTH_LIMIT) lx_depth++;
            end else if (c == sct_pkg::CH_RP) begin
                put_tok(sct_pkg::TOK_CLOSE, 8'h00, 1'b0);
                if (lx_depth > 0) lx_depth--;
                while (lx_stack_cnt > 0 && lx_stack[lx_stack_cnt - 1] == lx_depth) begin
                    put_tok(sct_pkg::TOK_CLOSE, 8'h00, 1'b0);
                    lx_stack_cnt--;
                end
            end else if (c == sct_pkg::CH_TICK) begin
                if (is_blank(it.next_char)) begin
                    put_tok(sct_pkg::TOK_ERROR, 8'h00, 1'b0);
                end else begin
                    put_tok(sct_pkg::TOK_OPEN, 8'h00, 1'b0);
                    put_tok(sct_pkg::TOK_QUOTE, 8'h00, 1'b0);
                    if (it.next_char == sct_pkg::CH_LP) begin
                        // quote chain wraps the list
                        for (int k = 0; k <= lx_word_closes; k++) begin
                            if (lx_stack_cnt < STACK_DEPTH) begin
                                lx_stack[lx_stack_cnt] = lx_depth;
                                lx_stack_cnt++;
                            end
                        end
                        lx_word_closes = 0;
                    end else if (lx_word_closes < WORD_QUOTE_MAX) begin
                        lx_word_closes++;
                    end
                end
            end
        end else begin
            if (c == sct_pkg::CH_DQUOTE) lx_in_string = !lx_in_string;
            put_tok(sct_pkg::TOK_CHAR, c, !lx_name_open);
            lx_name_open = 1'b1;
        end
        if (c == sct_pkg::CH_NL) begin
            if (lx_line < POS_LIMIT) lx_line++;
            lx_col = 0;
        end
        if (it.end_of_input) begin
            finish_name();
            flush_word_closes();
        end
        if (burst_toks.size() > 0) begin
            t = burst_toks.pop_back();
            t.last_in_run = 1'b1;
            burst_toks.push_back(t);
        end
        if (burst_toks.size() > max_burst) max_burst = burst_toks.size();
        if (burst_cut) cut_cnt++;
        if (lx_stack_cnt > max_stack) max_stack = lx_stack_cnt;
        if (lx_word_closes > max_pending) max_pending = lx_word_closes;
        foreach (burst_toks[i]) tok_expect.push_back(burst_toks[i]);
    endfunction

    function automatic void check_field(string fld, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            bad_cnt++;
            if (bad_cnt <= MAX_ERR_PRINTS)
                $display("%0t mismatch %s: expected %0h, actual %0h", $time, fld, want, got);
        end
    endfunction

    // stimulus generation
    function automatic logic [7:0] rand_name_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = 8'($urandom_range(8'h61, 8'h7A));
            1:       b = 8'($urandom_range(8'h80, 8'hFF));
            2:       b = 8'($urandom_range(8'h2A, 8'h3A));
            default: b = 8'($urandom_range(8'h00, 8'h1F));
        endcase
        if (is_blank(b)) b = 8'h3F;
        return b;
    endfunction

    function automatic logic [7:0] rand_special();
        case ($urandom_range(0, 7))
            0:       return sct_pkg::CH_SPACE;
            1:       return sct_pkg::CH_NL;
            2:       return sct_pkg::CH_TAB;
            3:       return sct_pkg::CH_SEMI;
            4:       return sct_pkg::CH_TICK;
            5:       return sct_pkg::CH_DQUOTE;
            6:       return sct_pkg::CH_LP;
            default: return sct_pkg::CH_RP;
        endcase
    endfunction

    function automatic logic [7:0] rand_sep();
        case ($urandom_range(0, 5))
            0:       return sct_pkg::CH_TAB;
            1:       return sct_pkg::CH_NL;
            default: return sct_pkg::CH_SPACE;
        endcase
    endfunction

    task automatic text_to_reqs();
        sct_pkg::t_in_item it;
        for (int i = 0; i < src_text.size(); i++) begin
            it.char_in      = src_text[i];
            it.next_char    = (i + 1 < src_text.size()) ? src_text[i + 1] : 8'h00;
            it.end_of_input = (i + 1 == src_text.size());
            req_q.push_back(it);
        end
        src_text.delete();
    endtask

    task automatic gen_form(int lvl);
        int pick;
        int n;
        if ($urandom_range(0, 99) < 25) begin
            n = ($urandom_range(0, 6) == 0) ? $urandom_range(3, 10) : $urandom_range(1, 2);
            repeat (n) src_text.push_back(sct_pkg::CH_TICK);
            if ($urandom_range(0, 9) == 0) src_text.push_back(rand_sep());
        end
        pick = $urandom_range(0, 99);
        if (pick < 45 || lvl >= 4) begin
            repeat ($urandom_range(1, 4)) src_text.push_back(rand_name_byte());
        end else if (pick < 75) begin
            src_text.push_back(sct_pkg::CH_LP);
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++) begin
                if (k > 0) src_text.push_back(rand_sep());
                gen_form(lvl + 1);
            end
            if ($urandom_range(0, 11) != 0) src_text.push_back(sct_pkg::CH_RP);
        end else if (pick < 88) begin
            src_text.push_back(sct_pkg::CH_DQUOTE);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 2) == 0) begin
                    pick = int'(rand_special());
                    src_text.push_back(pick == sct_pkg::CH_DQUOTE ? sct_pkg::CH_SEMI
                                                                  : 8'(pick));
                end else begin
                    src_text.push_back(rand_name_byte());
                end
            end
            src_text.push_back(sct_pkg::CH_DQUOTE);
        end else begin
            src_text.push_back(sct_pkg::CH_SEMI);
            repeat ($urandom_range(0, 5)) begin
                pick = $urandom_range(0, 255);
                src_text.push_back(pick == sct_pkg::CH_NL ? sct_pkg::CH_SPACE : 8'(pick));
            end
            src_text.push_back(sct_pkg::CH_NL);
        end
    endtask

    initial begin
        string             seed_text;
        sct_pkg::t_in_item it;
        int                target;

        // deep quote chain around a list, string with break bytes, comment,
        // tick before whitespace, dangling tick flushed by end of input
        seed_text = "'''(a '''''''b)\";)\"x;\n' '";
        foreach (seed_text[i]) src_text.push_back(seed_text[i]);
        src_text.push_back(8'hFF);
        src_text.push_back(8'h00);
        text_to_reqs();

        target = req_q.size() + RANDOM_ITEMS;
        while (req_q.size() < target) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(3, 12)) begin
                    it.char_in      = $urandom_range(0, 1) ? 8'($urandom) : rand_special();
                    it.next_char    = $urandom_range(0, 1) ? 8'($urandom) : rand_special();
                    it.end_of_input = ($urandom_range(0, 7) == 0);
                    req_q.push_back(it);
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    gen_form(0);
                    src_text.push_back(rand_sep());
                end
                gen_form(0);
                if ($urandom_range(0, 5) == 0) src_text.push_back(sct_pkg::CH_RP);
                text_to_reqs();
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() > 0 || i_in_valid) @(posedge i_clk);
        while (tok_expect.size() > 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);

        if (tok_expect.size() > 0) begin
            bad_cnt++;
            $display("%0t missing tokens: expected %0d more, actual none", $time,
                     tok_expect.size());
        end
        $display("covered %0d source bytes and %0d tokens, largest burst %0d, %0d bursts cut",
                 items_taken, toks_seen, max_burst, cut_cnt);
        $display("deepest quote stack %0d, most pending word quotes %0d, %0d mismatches",
                 max_stack, max_pending, bad_cnt);
        if (bad_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d requests and %0d tokens outstanding",
                 req_q.size(), tok_expect.size());
        $display("status: fail");
        $finish;
    end

    // driver: bursts of requests with random gaps
    int                burst_left = 1;
    int                gap_left   = 0;
    logic              send;
    sct_pkg::t_in_item next_req;

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            send = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (req_q.size() > 0) begin
                next_req = req_q.pop_front();
                send = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    if ($urandom_range(0, 4) == 0) begin
                        gap_left   = 0;
                        burst_left = $urandom_range(40, 120);
                    end else begin
                        gap_left   = $urandom_range(1, 8);
                        burst_left = $urandom_range(1, 20);
                    end
                end
            end
            i_in_valid <= send;
            if (send) i_in_item <= next_req;
        end
    end

    // receiver stall pattern
    t_rx_mode   rx_mode   = RX_OPEN;
    int         rx_left   = 0;
    logic [7:0] rx_phase  = '0;
    logic       rx_ready;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 150);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   rx_ready = 1'b1;
            RX_COIN:   rx_ready = 1'($urandom_range(0, 1));
            RX_SPARSE: rx_ready = ($urandom_range(0, 3) == 0);
            default:   rx_ready = rx_phase[2] ^ rx_phase[4];
        endcase
        rx_phase++;
        i_out_ready <= rx_ready;
    end

    // monitor: predict on accepted requests, check accepted tokens
    sct_pkg::t_out_item want;

    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        if (in_fire) begin
            lex_byte(i_in_item);
            items_taken++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            toks_seen++;
            if (tok_expect.size() == 0) begin
                bad_cnt++;
                if (bad_cnt <= MAX_ERR_PRINTS)
                    $display("%0t unexpected token: expected none, actual %h", $time,
                             o_out_item);
            end else begin
                want = tok_expect.pop_front();
                check_field("token_kind", 32'(want.token_kind), 32'(o_out_item.token_kind));
                check_field("token_char", 32'(want.token_char), 32'(o_out_item.token_char));
                check_field("token_start", 32'(want.token_start),
                            32'(o_out_item.token_start));
                check_field("line_number", 32'(want.line_number),
                            32'(o_out_item.line_number));
                check_field("column_number", 32'(want.column_number),
                            32'(o_out_item.column_number));
                check_field("last_in_run", 32'(want.last_in_run),
                            32'(o_out_item.last_in_run));
            end
        end
    end

endmodule

// ===== files.f =====
rtl/sct_pkg.sv
rtl/sct_front.sv
rtl/sct_queue.sv
rtl/sct_back.sv
rtl/sexpr_char_tokenizer.sv
test/tb_top.sv
